FILE: hw/rtl/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque package
// Shared types and codes for the double-ended queue controller and datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DATA_WIDTH = 32;

   // operation codes (3-bit field; 6 and 7 are ignored)
   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_LIST_FWD   = 3'd4,
      OP_LIST_REV   = 3'd5
   } op_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]                   op;
      logic signed [DATA_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] data;
      logic [1:0]                   status;
      logic                         last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_RESP,
      ST_LIST
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;        // capture request
      logic       push_back;
      logic       push_front;
      logic       pop_back;
      logic       pop_front;
      logic       list_start;
      logic       list_step;
      logic       emit;        // register a result
      logic       emit_rdata;  // result data from read register
      logic [1:0] emit_status;
      logic       emit_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] op;
      logic       empty;
      logic       full;
      logic       list_last;
   } stat_type;

endpackage : dq_pkg
`default_nettype wire

FILE: hw/rtl/dq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque controller
// Sequences one request at a time and issues datapath commands.
// ----------------------------------------------------------------------------
module dq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire dq_pkg::stat_type  stat,
   output dq_pkg::cmd_type        cmd
);

   dq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != dq_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = dq_pkg::ST_EXEC;
            end
         end
         dq_pkg::ST_EXEC: begin
            state_in = dq_pkg::ST_IDLE;
            unique case (stat.op) inside
               dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
                  cmd.emit      = 1'b1;
                  cmd.emit_last = 1'b1;
                  if (stat.full) begin
                     cmd.emit_status = dq_pkg::STATUS_FULL;
                  end else begin
                     cmd.emit_status = dq_pkg::STATUS_OK;
                     cmd.push_back   = (stat.op == dq_pkg::OP_PUSH_BACK);
                     cmd.push_front  = (stat.op == dq_pkg::OP_PUSH_FRONT);
                  end
               end
               dq_pkg::OP_POP_BACK, dq_pkg::OP_POP_FRONT: begin
                  if (stat.empty) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = dq_pkg::STATUS_EMPTY;
                  end else begin
                     cmd.pop_back  = (stat.op == dq_pkg::OP_POP_BACK);
                     cmd.pop_front = (stat.op == dq_pkg::OP_POP_FRONT);
                     state_in      = dq_pkg::ST_POP_RESP;
                  end
               end
               dq_pkg::OP_LIST_FWD, dq_pkg::OP_LIST_REV: begin
                  if (stat.empty) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = dq_pkg::STATUS_EMPTY;
                  end else begin
                     cmd.list_start = 1'b1;
                     state_in       = dq_pkg::ST_LIST;
                  end
               end
               default: begin
                  // unused op: no result
               end
            endcase
         end
         dq_pkg::ST_POP_RESP: begin
            cmd.emit        = 1'b1;
            cmd.emit_rdata  = 1'b1;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = dq_pkg::STATUS_OK;
            state_in        = dq_pkg::ST_IDLE;
         end
         dq_pkg::ST_LIST: begin
            cmd.emit        = 1'b1;
            cmd.emit_rdata  = 1'b1;
            cmd.emit_status = dq_pkg::STATUS_OK;
            cmd.emit_last   = stat.list_last;
            if (stat.list_last) begin
               state_in = dq_pkg::ST_IDLE;
            end else begin
               cmd.list_step = 1'b1;
            end
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule : dq_ctrl
`default_nettype wire

FILE: hw/rtl/dq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque datapath
// Ring store, head pointer, occupancy, list walker and result register.
// ----------------------------------------------------------------------------
module dq_datapath #(
   parameter int DEPTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dq_pkg::req_type  req_payload,
   input  wire dq_pkg::cmd_type  cmd,
   output dq_pkg::stat_type      stat,
   output logic                  rsp_strobe,
   output dq_pkg::rsp_type       rsp_payload
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int DW    = dq_pkg::DATA_WIDTH;

   logic [DW-1:0]    mem [DEPTH];

   logic [2:0]       op_ff;
   logic [DW-1:0]    value_ff;
   logic [PTR_W-1:0] head_ff;
   logic [OCC_W-1:0] occ_ff;
   logic [PTR_W-1:0] walk_ff;   // next list read address
   logic [OCC_W-1:0] cnt_ff;    // index of entry now in rdata_ff
   logic [DW-1:0]    rdata_ff;
   logic             rsp_strobe_ff;
   dq_pkg::rsp_type  rsp_ff;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      ptr_dec = (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
   endfunction

   // head + offset mod DEPTH, offset < DEPTH
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [OCC_W-1:0] o);
      logic [OCC_W:0] sum;
      sum = {{(OCC_W + 1 - PTR_W){1'b0}}, p} + {1'b0, o};
      if (sum >= (OCC_W + 1)'(DEPTH)) begin
         sum = sum - (OCC_W + 1)'(DEPTH);
      end
      ptr_add = sum[PTR_W-1:0];
   endfunction

   logic [PTR_W-1:0] tail;
   logic [PTR_W-1:0] back_slot;
   logic [PTR_W-1:0] head_dec;
   logic [PTR_W-1:0] list_first;
   logic             list_rev;
   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;

   always_comb begin
      tail       = ptr_add(head_ff, occ_ff - OCC_W'(1));
      back_slot  = ptr_add(head_ff, occ_ff);
      head_dec   = ptr_dec(head_ff);
      list_rev   = (op_ff == dq_pkg::OP_LIST_REV);
      list_first = list_rev ? tail : head_ff;

      wr_en   = cmd.push_back | cmd.push_front;
      wr_addr = cmd.push_front ? head_dec : back_slot;

      rd_en   = cmd.pop_back | cmd.pop_front | cmd.list_start | cmd.list_step;
      rd_addr = head_ff;
      if (cmd.pop_back) begin
         rd_addr = tail;
      end else if (cmd.list_start) begin
         rd_addr = list_first;
      end else if (cmd.list_step) begin
         rd_addr = walk_ff;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_payload.op;
         value_ff <= req_payload.value;
      end
   end

   // ring store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         occ_ff  <= '0;
      end else begin
         if (wr_en) begin
            occ_ff <= occ_ff + OCC_W'(1);
         end else if (cmd.pop_back | cmd.pop_front) begin
            occ_ff <= occ_ff - OCC_W'(1);
         end
         if (cmd.push_front) begin
            head_ff <= head_dec;
         end else if (cmd.pop_front) begin
            head_ff <= ptr_inc(head_ff);
         end
      end
   end

   // list walker
   always_ff @(posedge clock) begin
      if (cmd.list_start) begin
         cnt_ff  <= '0;
         walk_ff <= list_rev ? ptr_dec(list_first) : ptr_inc(list_first);
      end else if (cmd.list_step) begin
         cnt_ff  <= cnt_ff + OCC_W'(1);
         walk_ff <= list_rev ? ptr_dec(walk_ff) : ptr_inc(walk_ff);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.data   <= cmd.emit_rdata ? rdata_ff : '0;
         rsp_ff.status <= cmd.emit_status;
         rsp_ff.last   <= cmd.emit_last;
      end
   end

   assign stat.op        = op_ff;
   assign stat.empty     = (occ_ff == '0);
   assign stat.full      = (occ_ff == OCC_W'(DEPTH));
   assign stat.list_last = ((cnt_ff + OCC_W'(1)) == occ_ff);

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule : dq_datapath
`default_nettype wire

FILE: hw/rtl/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed values held in a ring store with head and count.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_payload (op, value) and raise start; the
//   transfer happens at a clock edge where start is high and busy is low.
//   Ops: push back/front, pop back/front, list front-to-back/back-to-front.
//   Response channel: each result sits on rsp_payload for one cycle with
//   rsp_strobe high; the receiver cannot stall, so it must take every result.
//   rsp_payload.last marks the final result of a request.
// Sequencing (one request in flight at a time, set by the controller states):
//   push   : exec state checks full and writes; the result register strobes.
//   pop    : exec state reads the store; pop-response state emits the data.
//   list   : exec state reads the first entry; list state then emits one result
//            per cycle and reads the next, until the last stored entry;
//            an empty queue gives one empty-status result.
//   Push when full returns status full; pop/list when empty returns empty.
//   Op codes 6 and 7 are dropped with no result.
// Reset (synchronous, active high) empties the queue; store contents are not
// cleared and are never read before being written.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire dq_pkg::req_type  req_payload,
   output logic                  rsp_strobe,
   output dq_pkg::rsp_type       rsp_payload
);

   dq_pkg::cmd_type  cmd;
   dq_pkg::stat_type stat;

   // sequencer: one request at a time
   dq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // ring store, pointers and registered result
   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule : double_ended_queue
`default_nettype wire

FILE: tb/sv/double_ended_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Sends push, pop and listing commands through the start/busy port, keeps its
// own copy of the ring store to work out every result, and checks each
// strobed result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
   import dq_pkg::*;

   localparam int DEPTH        = 64;
   localparam int RANDOM_ITEMS = 190;
   localparam int QUIET_TAIL   = 40;         // last commands go out with no gaps
   localparam int SETTLE       = DEPTH + 10; // a full listing plus margin
   localparam int CYCLE_LIMIT  = 200000;

   // op codes outside the enum; the block drops them without a result
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   double_ended_queue #(
      .DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   // --------------------------------------------------------------------------
   // Clock: 20 ns period
   // --------------------------------------------------------------------------
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // commands waiting to go out, and results owed by the block
   req_type command_queue[$];
   rsp_type owed_results[$];

   // shadow copy of the deque: ring store, front index and fill count
   logic signed [DATA_WIDTH-1:0] deque_ring [DEPTH];
   int deque_head  = 0;
   int deque_count = 0;

   int error_count = 0;
   int cycle_count = 0;
   int idle_left   = 0;
   int gen_count   = 0; // fill level as the command list is built

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $realtime, what);
      error_count++;
   endtask

   function automatic rsp_type make_result(input logic signed [DATA_WIDTH-1:0] data,
                                           input logic [1:0] status,
                                           input logic last);
      rsp_type r;
      r.data   = data;
      r.status = status;
      r.last   = last;
      return r;
   endfunction

   // Apply one accepted command to the shadow deque and queue its results.
   task automatic deque_apply(input req_type cmd);
      int idx;
      int off;
      case (cmd.op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (deque_count >= DEPTH) begin
               owed_results.push_back(make_result('0, STATUS_FULL, 1'b1));
            end else begin
               if (cmd.op == OP_PUSH_FRONT) begin
                  deque_head = (deque_head + DEPTH - 1) % DEPTH;
                  idx = deque_head;
               end else begin
                  idx = (deque_head + deque_count) % DEPTH;
               end
               deque_ring[idx] = cmd.value;
               deque_count++;
               owed_results.push_back(make_result('0, STATUS_OK, 1'b1));
            end
         end
         OP_POP_BACK, OP_POP_FRONT: begin
            if (deque_count == 0) begin
               owed_results.push_back(make_result('0, STATUS_EMPTY, 1'b1));
            end else begin
               if (cmd.op == OP_POP_BACK) begin
                  idx = (deque_head + deque_count - 1) % DEPTH;
               end else begin
                  idx = deque_head;
                  deque_head = (deque_head + 1) % DEPTH;
               end
               owed_results.push_back(make_result(deque_ring[idx], STATUS_OK, 1'b1));
               deque_count--;
            end
         end
         OP_LIST_FWD, OP_LIST_REV: begin
            if (deque_count == 0) begin
               owed_results.push_back(make_result('0, STATUS_EMPTY, 1'b1));
            end else begin
               for (int i = 0; i < deque_count; i++) begin
                  off = (cmd.op == OP_LIST_FWD) ? i : deque_count - 1 - i;
                  owed_results.push_back(make_result(deque_ring[(deque_head + off) % DEPTH],
                                                     STATUS_OK, i == deque_count - 1));
               end
            end
         end
         default: ; // spare op codes: no state change, no result
      endcase
   endtask

   // Queue a command and track the fill level it leaves behind, so the
   // random part can steer toward full and back toward empty.
   task automatic add_command(input logic [2:0] op, input logic signed [DATA_WIDTH-1:0] value);
      req_type cmd;
      cmd.op    = op;
      cmd.value = value;
      command_queue.push_back(cmd);
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: if (gen_count < DEPTH) gen_count++;
         OP_POP_BACK, OP_POP_FRONT:   if (gen_count > 0) gen_count--;
         default: ;
      endcase
   endtask

   // Mostly full-range random values, with the extremes mixed in.
   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
         1:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Driver: a transfer happens at an edge with start high and busy low. The
   // accepted command is applied to the shadow deque at that same edge, using
   // the payload value the block sampled. start stays high across back-to-back
   // transfers; it drops only for an idle burst or when nothing is left.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      if (!reset) begin
         if (start && !busy) begin
            deque_apply(req_payload);
         end
         if (start && busy) begin
            // hold the command until the block takes it
         end else if (idle_left != 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (command_queue.size() != 0) begin
            if (command_queue.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
               idle_left = $urandom_range(1, 10) - 1;
               start <= 1'b0;
            end else begin
               req_payload <= command_queue.pop_front();
               start       <= 1'b1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: the receiver cannot stall, so every strobe is one result.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_strobe) begin
         got = rsp_payload;
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result data=%0d status=%0d last=%0d",
                                      got.data, got.status, got.last));
         end else begin
            want = owed_results.pop_front();
            if (got.data !== want.data || got.status !== want.status
                || got.last !== want.last) begin
               report_mismatch($sformatf(
                  "result mismatch: data=%0d/%0d status=%0d/%0d last=%0d/%0d (got/want)",
                  got.data, want.data, got.status, want.status, got.last, want.last));
            end
         end
      end
   end

   // Timeout guard: a hang ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus and end of run
   // --------------------------------------------------------------------------
   initial begin
      int   issued;
      int   roll;
      logic filling;

      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;

      // Directed: empty-queue pops and listings, spare op codes, the value
      // extremes, a front push that wraps the head below zero, both listing
      // orders, then draining from both ends back to empty.
      add_command(OP_POP_BACK,   pick_value());
      add_command(OP_POP_FRONT,  pick_value());
      add_command(OP_LIST_FWD,   '0);
      add_command(OP_LIST_REV,   '1);
      add_command(OP_SPARE_6,    pick_value());
      add_command(OP_SPARE_7,    pick_value());
      add_command(OP_PUSH_BACK,  {1'b0, {(DATA_WIDTH-1){1'b1}}});
      add_command(OP_PUSH_FRONT, {1'b1, {(DATA_WIDTH-1){1'b0}}});
      add_command(OP_PUSH_BACK,  '0);
      add_command(OP_PUSH_FRONT, '1);
      add_command(OP_SPARE_7,    '1);
      add_command(OP_LIST_FWD,   '0);
      add_command(OP_LIST_REV,   '0);
      add_command(OP_POP_FRONT,  '0);
      add_command(OP_POP_BACK,   '0);
      add_command(OP_POP_FRONT,  '0);
      add_command(OP_POP_BACK,   '0);
      add_command(OP_POP_BACK,   '0);
      add_command(OP_LIST_FWD,   '0);

      // Random: alternate fill and drain phases so the ring goes full (with
      // pushes refused) and back to empty (with pops refused), mixing ends
      // so the head wraps both ways. Listings land at varied fill levels.
      filling = 1'b1;
      issued  = 0;
      while (issued < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            // spare op codes are noise and do not count
            add_command($urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6, pick_value());
         end else begin
            if (roll < 11) begin
               add_command($urandom_range(0, 1) ? OP_LIST_REV : OP_LIST_FWD, pick_value());
            end else if ((roll < 80) == filling) begin
               add_command($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
            end else begin
               add_command($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_value());
            end
            issued++;
            if (filling && gen_count == DEPTH) begin
               add_command(OP_PUSH_BACK,  pick_value());
               add_command(OP_PUSH_FRONT, pick_value());
               add_command(OP_LIST_REV,   pick_value());
               issued += 3;
               filling = 1'b0;
            end else if (!filling && gen_count == 0) begin
               add_command(OP_POP_FRONT, pick_value());
               issued++;
               filling = 1'b1;
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // every command handed over, every result in, then watch for strays
      while (command_queue.size() != 0 || start) @(posedge clock);
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
